/* sv/rgpsq_pkg.sv */
package rgpsq_pkg;

    // Default sizes
    localparam int DEF_PEER_SLOTS  = 16;
    localparam int DEF_QUEUE_DEPTH = 64;

    // Fixed field widths
    localparam int REV_W    = 64;
    localparam int HOST_W   = 64;
    localparam int PORT_W   = 16;
    localparam int HANDLE_W = 32;
    localparam int LEN_W    = 16;
    localparam int QCNT_W   = 7;
    localparam int PCNT_W   = 5;
    localparam int KIND_W   = 3;

    // Packed stream widths
    localparam int IN_BITS   = 2 * HOST_W + 1 + PORT_W + HANDLE_W + LEN_W + 1 + REV_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 2 + REV_W + HANDLE_W + LEN_W + QCNT_W + PCNT_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [REV_W-1:0] REV_MAX = '1;

    // Request codes
    typedef enum logic [KIND_W-1:0] {
        OP_UPSERT  = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_ADVANCE = 3'd2,
        OP_ENQUEUE = 3'd3,
        OP_TAKE    = 3'd4
    } t_op;

    // Classified request handed from front to back
    typedef struct packed {
        logic                op_ok;
        t_op                 op;
        logic [HOST_W-1:0]   host_high;
        logic [HOST_W-1:0]   host_low;
        logic                host_null;
        logic [PORT_W-1:0]   peer_port;
        logic                port_nz;
        logic [HANDLE_W-1:0] payload_handle;
        logic [LEN_W-1:0]    payload_length;
        logic                len_nz;
        logic                use_expected;
        logic [REV_W-1:0]    expected_revision;
    } t_req;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAKE_RD,
        ST_TAKE_CHK,
        ST_EXEC
    } t_state;

endpackage

/* sv/rgpsq_front.sv */
module rgpsq_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata: host_high, host_low, host_null, peer_port, payload_handle,
    //        payload_length, use_expected, expected_revision, zero pad
    input  logic [rgpsq_pkg::IN_DATA_W-1:0] i_s_tdata,
    // tuser: kind
    input  logic [rgpsq_pkg::KIND_W-1:0]  i_s_tuser,
    output logic                          o_req_valid,
    input  logic                          i_req_ready,
    output rgpsq_pkg::t_req               o_req
);
    import rgpsq_pkg::*;

    localparam int FQ_DEPTH = 2;

    t_req       w_req;
    t_req       r_fifo [FQ_DEPTH];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop;

    // Unpack and classify the incoming request
    always_comb begin
        w_req = '0;
        w_req.host_high         = i_s_tdata[63:0];
        w_req.host_low          = i_s_tdata[127:64];
        w_req.host_null         = i_s_tdata[128];
        w_req.peer_port         = i_s_tdata[144:129];
        w_req.payload_handle    = i_s_tdata[176:145];
        w_req.payload_length    = i_s_tdata[192:177];
        w_req.use_expected      = i_s_tdata[193];
        w_req.expected_revision = i_s_tdata[257:194];
        w_req.port_nz           = (w_req.peer_port != '0);
        w_req.len_nz            = (w_req.payload_length != '0);
        w_req.op                = OP_ADVANCE;
        w_req.op_ok             = 1'b0;
        case (i_s_tuser)
            OP_UPSERT, OP_REMOVE, OP_ADVANCE, OP_ENQUEUE, OP_TAKE: begin
                w_req.op    = t_op'(i_s_tuser);
                w_req.op_ok = 1'b1;
            end
            default: begin
                w_req.op_ok = 1'b0;
            end
        endcase
    end

    assign o_s_tready  = (r_cnt != 2'(FQ_DEPTH));
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_fifo[r_rp];
    assign w_push      = i_s_tvalid && o_s_tready;
    assign w_pop       = o_req_valid && i_req_ready;

    // Pointer and count update
    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp] <= w_req;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(FQ_DEPTH)) else $error("front queue overfilled");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'(FQ_DEPTH)) |-> (r_wp == r_rp))
        else $error("front pointers disagree with count");
    a_push_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt != 2'd0)) else $error("push lost");
`endif

endmodule

/* sv/rgpsq_back.sv */
module rgpsq_back #(
    parameter int PEER_SLOTS  = rgpsq_pkg::DEF_PEER_SLOTS,
    parameter int QUEUE_DEPTH = rgpsq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rgpsq_pkg::REV_W-1:0]     i_cfg_wdata,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  rgpsq_pkg::t_req                 i_req,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata: accepted, changed, revision, out_handle, out_length,
    //        queue_count, peer_count, exhausted, zero pad
    output logic [rgpsq_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import rgpsq_pkg::*;

    localparam int IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int PW = $clog2(PEER_SLOTS + 1);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    t_state                r_state, n_state;
    t_req                  r_req, n_req;
    logic [REV_W-1:0]      r_rev, n_rev;
    logic                  r_exh, n_exh;
    logic [PEER_SLOTS-1:0] r_used, n_used;
    logic [PW-1:0]         r_peer, n_peer;
    logic [QW-1:0]         r_head, n_head;
    logic [QW-1:0]         r_tail, n_tail;
    logic [FW-1:0]         r_fill, n_fill;
    logic [IW-1:0]         r_scan, n_scan;
    logic                  r_found, n_found;
    logic [IW-1:0]         r_fidx, n_fidx;
    logic                  r_free_ok, n_free_ok;
    logic [IW-1:0]         r_free, n_free;
    logic                  r_hit, n_hit;
    logic [HANDLE_W-1:0]   r_oh, n_oh;
    logic [LEN_W-1:0]      r_ol, n_ol;
    logic                  r_ov, n_ov;
    logic [OUT_DATA_W-1:0] r_od, n_od;

    // Peer table payload
    logic [HOST_W-1:0]     r_thh [PEER_SLOTS];
    logic [HOST_W-1:0]     r_thl [PEER_SLOTS];
    logic [PORT_W-1:0]     r_tport [PEER_SLOTS];
    logic                  w_tbl_we;
    logic [IW-1:0]         w_tbl_idx;

    // Send queue memory
    logic [HANDLE_W-1:0]   r_qh [QUEUE_DEPTH];
    logic [LEN_W-1:0]      r_ql [QUEUE_DEPTH];
    logic [REV_W-1:0]      r_qr [QUEUE_DEPTH];
    logic [HANDLE_W-1:0]   r_rd_h;
    logic [LEN_W-1:0]      r_rd_l;
    logic [REV_W-1:0]      r_rd_r;
    logic                  w_q_we;

    logic                  w_out_free;
    logic                  w_match;
    logic                  w_acc, w_chg, w_adv_ok;
    logic [IW-1:0]         w_dst;
    logic [REV_W-1:0]      w_want;

    assign w_out_free  = !r_ov || i_m_tready;
    assign o_req_ready = (r_state == ST_IDLE);
    assign o_m_tvalid  = r_ov;
    assign o_m_tdata   = r_od;
    assign w_match     = r_used[r_scan] && (r_thh[r_scan] == r_req.host_high)
                         && (r_thl[r_scan] == r_req.host_low);

    // Sequencer: next state and table/queue updates
    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_rev     = r_rev;
        n_exh     = r_exh;
        n_used    = r_used;
        n_peer    = r_peer;
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_scan    = r_scan;
        n_found   = r_found;
        n_fidx    = r_fidx;
        n_free_ok = r_free_ok;
        n_free    = r_free;
        n_hit     = r_hit;
        n_oh      = r_oh;
        n_ol      = r_ol;
        n_ov      = r_ov && !i_m_tready;
        n_od      = r_od;
        w_tbl_we  = 1'b0;
        w_tbl_idx = r_fidx;
        w_q_we    = 1'b0;
        w_acc     = 1'b0;
        w_chg     = 1'b0;
        w_adv_ok  = 1'b0;
        w_dst     = r_found ? r_fidx : r_free;
        w_want    = r_req.use_expected ? r_req.expected_revision : r_rev;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_req     = i_req;
                    n_scan    = '0;
                    n_found   = 1'b0;
                    n_free_ok = 1'b0;
                    n_hit     = 1'b0;
                    n_state   = ST_EXEC;
                    if (i_req.op_ok && !r_exh && !i_req.host_null &&
                        (i_req.op == OP_REMOVE ||
                         (i_req.op == OP_UPSERT && i_req.port_nz))) begin
                        n_state = ST_SCAN;
                    end else if (i_req.op_ok && i_req.op == OP_TAKE &&
                                 r_fill != '0) begin
                        n_state = ST_TAKE_RD;
                    end
                end
            end
            // One table entry per cycle: first match, first free slot
            ST_SCAN: begin
                if (w_match) begin
                    n_found = 1'b1;
                    n_fidx  = r_scan;
                    n_state = ST_EXEC;
                end else begin
                    if (!r_used[r_scan] && !r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_scan;
                    end
                    if (r_scan == IW'(PEER_SLOTS - 1)) begin
                        n_state = ST_EXEC;
                    end else begin
                        n_scan = r_scan + 1'b1;
                    end
                end
            end
            ST_TAKE_RD: begin
                n_state = ST_TAKE_CHK;
            end
            // Pop head; keep it only if its tag is current
            ST_TAKE_CHK: begin
                n_head = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                n_fill = r_fill - 1'b1;
                if (!r_exh && r_rd_r == r_rev) begin
                    n_hit   = 1'b1;
                    n_oh    = r_rd_h;
                    n_ol    = r_rd_l;
                    n_state = ST_EXEC;
                end else if (n_fill != '0) begin
                    n_state = ST_TAKE_RD;
                end else begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_out_free) begin
                    if (r_req.op_ok) begin
                        case (r_req.op)
                            OP_UPSERT: begin
                                if (!r_exh && !r_req.host_null && r_req.port_nz) begin
                                    if (r_found && r_tport[r_fidx] == r_req.peer_port) begin
                                        w_acc = 1'b1;
                                    end else if (r_found || r_free_ok) begin
                                        if (r_rev == REV_MAX) begin
                                            n_exh  = 1'b1;
                                            n_used = '0;
                                            n_peer = '0;
                                            n_head = '0;
                                            n_tail = '0;
                                            n_fill = '0;
                                        end else begin
                                            n_rev    = r_rev + 1'b1;
                                            w_adv_ok = 1'b1;
                                        end
                                        if (w_adv_ok) begin
                                            w_tbl_we     = 1'b1;
                                            w_tbl_idx    = w_dst;
                                            n_used[w_dst] = 1'b1;
                                            if (!r_found) begin
                                                n_peer = r_peer + 1'b1;
                                            end
                                            w_acc = 1'b1;
                                            w_chg = 1'b1;
                                        end
                                    end
                                end
                            end
                            OP_REMOVE: begin
                                if (!r_exh && !r_req.host_null) begin
                                    if (!r_found) begin
                                        w_acc = 1'b1;
                                    end else if (r_rev == REV_MAX) begin
                                        n_exh  = 1'b1;
                                        n_used = '0;
                                        n_peer = '0;
                                        n_head = '0;
                                        n_tail = '0;
                                        n_fill = '0;
                                    end else begin
                                        n_rev          = r_rev + 1'b1;
                                        n_used[r_fidx] = 1'b0;
                                        n_peer         = r_peer - 1'b1;
                                        w_acc          = 1'b1;
                                        w_chg          = 1'b1;
                                    end
                                end
                            end
                            OP_ADVANCE: begin
                                if (!r_exh) begin
                                    if (r_rev == REV_MAX) begin
                                        n_exh  = 1'b1;
                                        n_used = '0;
                                        n_peer = '0;
                                        n_head = '0;
                                        n_tail = '0;
                                        n_fill = '0;
                                    end else begin
                                        n_rev = r_rev + 1'b1;
                                        w_acc = 1'b1;
                                    end
                                end
                            end
                            OP_ENQUEUE: begin
                                if (!r_exh && r_req.len_nz && w_want == r_rev &&
                                    r_peer != '0 && r_fill != FW'(QUEUE_DEPTH)) begin
                                    w_q_we = 1'b1;
                                    n_tail = (r_tail == QW'(QUEUE_DEPTH - 1)) ?
                                             '0 : r_tail + 1'b1;
                                    n_fill = r_fill + 1'b1;
                                    w_acc  = 1'b1;
                                end
                            end
                            OP_TAKE: begin
                                w_acc = r_hit;
                            end
                            default: begin
                                w_acc = 1'b0;
                            end
                        endcase
                    end
                    n_od = '0;
                    n_od[0]       = w_acc;
                    n_od[1]       = w_chg;
                    n_od[65:2]    = w_acc ? n_rev : '0;
                    n_od[97:66]   = (w_acc && r_req.op == OP_TAKE) ? r_oh : '0;
                    n_od[113:98]  = (w_acc && r_req.op == OP_TAKE) ? r_ol : '0;
                    n_od[120:114] = QCNT_W'(n_fill);
                    n_od[125:121] = PCNT_W'(n_peer);
                    n_od[126]     = n_exh;
                    n_ov          = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_cfg_we) begin
            n_rev = i_cfg_wdata;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rev   <= '0;
            r_exh   <= 1'b0;
            r_used  <= '0;
            r_peer  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rev   <= n_rev;
            r_exh   <= n_exh;
            r_used  <= n_used;
            r_peer  <= n_peer;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
            r_ov    <= n_ov;
        end
    end

    // Request and search scratch
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_scan    <= n_scan;
        r_found   <= n_found;
        r_fidx    <= n_fidx;
        r_free_ok <= n_free_ok;
        r_free    <= n_free;
        r_hit     <= n_hit;
        r_oh      <= n_oh;
        r_ol      <= n_ol;
        r_od      <= n_od;
    end

    // Peer table write
    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_thh[w_tbl_idx]   <= r_req.host_high;
            r_thl[w_tbl_idx]   <= r_req.host_low;
            r_tport[w_tbl_idx] <= r_req.peer_port;
        end
    end

    // Queue memory: write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (w_q_we) begin
            r_qh[r_tail] <= r_req.payload_handle;
            r_ql[r_tail] <= r_req.payload_length;
            r_qr[r_tail] <= r_rev;
        end
        r_rd_h <= r_qh[r_head];
        r_rd_l <= r_ql[r_head];
        r_rd_r <= r_qr[r_head];
    end

`ifndef SYNTHESIS
    a_exh_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exh |-> (r_peer == '0 && r_fill == '0 && r_used == '0))
        else $error("exhausted with live state");
    a_exh_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exh |=> r_exh) else $error("exhaustion latch dropped");
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(QUEUE_DEPTH)) else $error("queue overfilled");
    a_peer_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == int'(r_peer)) else $error("peer count drift");
    a_exh_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_od[126]) |-> !r_od[0]) else $error("accepted while exhausted");
`endif

endmodule

/* sv/revision_gated_peer_send_queue_core.sv */
// Channel   Dir  Handshake            Payload
// s         in   i_s_tvalid/o_s_tready  tdata: request fields, tuser: kind
// m         out  o_m_tvalid/i_m_tready  tdata: result fields
// cfg       in   i_cfg_we               i_cfg_wdata: initial_revision
//
// Advance and enqueue go straight to execute; upsert and remove first run
// the one-entry-per-cycle peer table search; take first drains queue
// slots through the single queue read port, stopping at a current entry.
// Reset (synchronous, low) clears revision to 0, exhaustion, table and queue.
// A two-entry request queue lets the input run while a result waits.
module revision_gated_peer_send_queue_core #(
    parameter int PEER_SLOTS  = rgpsq_pkg::DEF_PEER_SLOTS,
    parameter int QUEUE_DEPTH = rgpsq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rgpsq_pkg::REV_W-1:0]      i_cfg_wdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: host_high, host_low, host_null, peer_port, payload_handle,
    //        payload_length, use_expected, expected_revision, zero pad
    input  logic [rgpsq_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: kind
    input  logic [rgpsq_pkg::KIND_W-1:0]     i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: accepted, changed, revision, out_handle, out_length,
    //        queue_count, peer_count, exhausted, zero pad
    output logic [rgpsq_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import rgpsq_pkg::*;

    t_req w_req;
    logic w_req_valid;
    logic w_req_ready;

    rgpsq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_req_valid (w_req_valid),
        .i_req_ready (w_req_ready),
        .o_req       (w_req)
    );

    rgpsq_back #(
        .PEER_SLOTS  (PEER_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (w_req_valid),
        .o_req_ready (w_req_ready),
        .i_req       (w_req),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule
